// ----- src/plfc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plfc_pkg: shared types and constants
// Register indexes, mode codes and field widths for the float compare.
// ---------------------------------------------------------------------------
package plfc_pkg;

   localparam int MANT_F = 23;
   localparam int MANT_D = 52;
   localparam logic [10:0] REBIAS = 11'd896;

   typedef enum logic [1:0] {
      CSR_TYPE_MODE   = 2'd0,
      CSR_FIRST_PREC  = 2'd1,
      CSR_SECOND_PREC = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_SS = 2'd0,
      MODE_DD = 2'd1,
      MODE_SD = 2'd2,
      MODE_XX = 2'd3
   } mode_type;

   // Decoded precision: full flag plus 6-bit count.
   typedef struct packed {
      logic       full;
      logic [5:0] bits;
   } prec_type;

   // Mask keeping sign, exponent and p top mantissa bits of a double.
   function automatic logic [63:0] dbl_mask(input logic [5:0] p);
      logic [63:0] m;
      m = ~64'd0 << (7'(MANT_D) - {1'b0, p});
      return m;
   endfunction

endpackage

// ----- src/plfc_round.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plfc_round: double to single and back
// Rounds a double to single (nearest even), then widens it exactly.
// ---------------------------------------------------------------------------
module plfc_round import plfc_pkg::*; (
   input  logic [63:0] d,
   output logic [63:0] w
);
   logic        s;
   logic [10:0] e;
   logic [51:0] m;
   logic [52:0] sig;
   logic signed [12:0] ef;
   logic [5:0]  sh;
   logic [52:0] q;
   logic [53:0] rem, half;
   logic [24:0] qr;
   logic [31:0] f;
   logic [7:0]  fe;
   logic [22:0] fm;
   logic [4:0]  k;
   logic [51:0] sm;

   always_comb begin
      s    = d[63];
      e    = d[62:52];
      m    = d[51:0];
      sig  = {1'b1, m};
      ef   = 13'($signed({2'b0, e})) - 13'sd896;
      sh   = (ef >= 1) ? 6'd29 : ((ef < -24) ? 6'd55 : 6'(30 - ef));
      f    = {s, 31'd0};
      q    = '0; rem = '0; half = '0; qr = '0;
      if (e == 11'h7FF) begin
         f = (m == 0) ? {s, 31'h7F800000} : {s, 8'hFF, 1'b1, m[50:29]};
      end else if (e != 0 && sh <= 6'd54) begin
         // remainder and half-point kept one bit wider: half reaches 2^53
         q    = sig >> sh;
         rem  = {1'b0, sig} & ((54'd1 << sh) - 54'd1);
         half = 54'd1 << (sh - 6'd1);
         qr   = 25'(q) + 25'((rem > half || (rem == half && q[0])) ? 1 : 0);
         if (ef >= 1) begin
            if (qr[24]) begin
               qr = qr >> 1;
               ef = ef + 13'sd1;
            end
            if (ef >= 255) f = {s, 31'h7F800000};
            else f = {s, ef[7:0], qr[22:0]};
         end else begin
            f = {s, 31'(qr)};
         end
      end
      // exact widening
      fe = f[30:23];
      fm = f[22:0];
      k  = 5'd0;
      for (int i = 0; i < 23; i++) if (fm[i]) k = 5'(i);
      sm = 52'(fm) << (6'd52 - {1'b0, k});
      if (fe == 8'hFF)
         w = {f[31], 11'h7FF, fm, 29'd0};
      else if (fe == 0)
         w = (fm == 0) ? {f[31], 63'd0}
                       : {f[31], 11'(11'd874 + 11'(k)), sm};
      else
         w = {f[31], 11'(11'(fe) + 11'd896), fm, 29'd0};
   end
endmodule

// ----- src/plfc_cmp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plfc_cmp: precision compare
// Applies mode, precisions and null rules to one registered operand pair.
// ---------------------------------------------------------------------------
module plfc_cmp import plfc_pkg::*; (
   input  logic [1:0]  mode,
   input  prec_type    p1,
   input  prec_type    p2,
   input  logic [63:0] a,
   input  logic        n1,
   input  logic [63:0] b,
   input  logic        n2,
   output logic        match
);
   logic [63:0] wd, wf, x, y;
   logic        lt12, lt21;

   plfc_round u_round (.d(b), .w(wd));

   always_comb begin
      lt12 = !p1.full && (p2.full || p1.bits < p2.bits);
      lt21 = !p2.full && (p1.full || p2.bits < p1.bits);
      x = a; y = b;
      wf = '0;
      case (mode)
         MODE_SS: begin
            x = {32'd0, a[31:0]}; y = {32'd0, b[31:0]};
            if (lt12 && p1.bits < 6'(MANT_F)) y = y & (dbl_mask(p1.bits) >> 29);
            if (lt21 && p2.bits < 6'(MANT_F)) x = x & (dbl_mask(p2.bits) >> 29);
         end
         MODE_SD: begin
            wf = {a[31], 3'd0, a[30:23], a[22:0], 29'd0};
            if (a[31:0] != 0) wf[62:52] = {3'd0, a[30:23]} + REBIAS;
            x = wf; y = wd;
            if (lt12 && p1.bits < 6'(MANT_D)) y = wd & dbl_mask(p1.bits);
            else if (p1.full && (p2.full || p2.bits > 6'(MANT_F)))
               y = wd & dbl_mask(6'(MANT_F));
            if (lt21 && p2.bits < 6'(MANT_F)) x = wf & dbl_mask(p2.bits);
         end
         default: begin
            if (lt12 && p1.bits < 6'(MANT_D)) y = b & dbl_mask(p1.bits);
            if (lt21 && p2.bits < 6'(MANT_D)) x = a & dbl_mask(p2.bits);
         end
      endcase
      match = n1 ? n2 : (x == y);
   end
endmodule

// ----- src/precision_limited_float_compare_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// precision_limited_float_compare_top
// Compares two IEEE patterns for equality up to per-file mantissa precision.
// ---------------------------------------------------------------------------
// One beat is taken in any cycle with start high (busy is always low); the
// operands are registered, compared in one pass of logic, and the result is
// registered. rsp_valid and rsp_values_match come from o_ff and m_ff, fed by
// input registers v_ff, a_ff, b_ff, n1_ff, n2_ff: two register stages, one
// result per beat, one beat per cycle. The receiver cannot stall: each result
// is shown for one cycle only. The user must write configuration through
// csr_we/csr_index/csr_wdata with no beat in flight; the block has no guard.
module precision_limited_float_compare_top import plfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_first_bits,
   input  logic        req_first_is_null,
   input  logic [63:0] req_second_bits,
   input  logic        req_second_is_null,
   output logic        rsp_valid,
   output logic        rsp_values_match,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   logic [1:0]  mode_ff;
   prec_type    p1_ff, p2_ff;
   logic        v_ff, o_ff, m_ff, match;
   logic [63:0] a_ff, b_ff;
   logic        n1_ff, n2_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SS;
         p1_ff   <= '{full: 1'b1, bits: 6'd0};
         p2_ff   <= '{full: 1'b1, bits: 6'd0};
         v_ff    <= 1'b0;
         o_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TYPE_MODE:   mode_ff <= csr_wdata[1:0];
               CSR_FIRST_PREC:  p1_ff <= '{full: csr_wdata[6], bits: csr_wdata[5:0]};
               CSR_SECOND_PREC: p2_ff <= '{full: csr_wdata[6], bits: csr_wdata[5:0]};
               default: ;
            endcase
         end
         v_ff <= start;
         o_ff <= v_ff;
      end
      a_ff  <= req_first_bits;
      b_ff  <= req_second_bits;
      n1_ff <= req_first_is_null;
      n2_ff <= req_second_is_null;
      m_ff  <= match;
   end

   plfc_cmp u_cmp (
      .mode(mode_ff), .p1(p1_ff), .p2(p2_ff),
      .a(a_ff), .n1(n1_ff), .b(b_ff), .n2(n2_ff), .match(match)
   );

   assign rsp_valid        = o_ff;
   assign rsp_values_match = m_ff;

   a_pipe: assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 rsp_valid) else $error("result lost");
   a_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2)) else $error("result invented");
   a_null: assert property (@(posedge clock) disable iff (reset)
      v_ff && n1_ff |=> m_ff == $past(n2_ff)) else $error("null rule");
endmodule
